// File: src/vt4_pkg.sv
// Shared types and constants for the 4x4 vertex transform unit.
`default_nettype none

package vt4_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned MAT_ENTRIES = 16;
  localparam int unsigned MAT_DIM     = 4;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes carried through the queue.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  // One classified command. For a matrix write, operand 0 holds the entry value.
  typedef struct packed {
    op_e                             op;
    logic [INDEX_W-1:0]              index;
    logic [MAT_DIM-1:0][WORD_W-1:0]  opnd;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/vt4_if.sv
// Channel interfaces for the vertex transform unit: input items and result items.
`default_nettype none

interface vt4_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] vec_w;

  modport source (
    output valid, func, entry_index, entry_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface vt4_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic        overflow;

  modport source (
    output valid, out_x, out_y, out_z, out_w, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, overflow,
    output ready
  );
endinterface

`default_nettype wire

// File: src/vertex_transform_4x4_unit.sv
// Top level of the 4x4 vertex transform unit.
//
// Input channel in_i carries one transaction per item. func 0 writes one entry
// of the 4x4 Q16.16 matrix (row-major entry_index, entry_value) and gives no
// result. func 1 gives a vertex (vec_x..vec_w) and produces one result on out_o:
// the four row dot products, floor-shifted by FRAC_BITS and saturated to
// 32 bits, with overflow set if any component saturated.
// Commands pass through a two-entry queue into the back end, so a transform
// uses the matrix as written by all earlier items and no later ones.
// A result passes from the queue register through the product stage, the adder
// stage and the output register. Throughput: one item per cycle while out_o is
// ready, writes and transforms mixed freely; the product stage with its sixteen
// 32x32 multipliers takes one vertex each cycle.
// When the receiver holds ready low, results back up through the stages and
// the queue; ready on in_i falls once the queue is full.
// Reset clears the matrix to zero and empties the queue and all stages.
`default_nettype none

module vertex_transform_4x4_unit #(
  parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vt4_in_if.sink      in_i,
  vt4_out_if.source   out_o
);

  vt4_pkg::cmd_t head;
  logic          head_valid;
  logic          pop;

  vt4_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  vt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: src/vt4_front.sv
// Front end: accepts input transactions, classifies them and queues the commands.
`default_nettype none

module vt4_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  vt4_in_if.sink             in_i,
  output vt4_pkg::cmd_t      head_o,
  output logic               head_valid_o,
  input  wire logic          pop_i
);

  vt4_pkg::cmd_t                   queue_q [vt4_pkg::QUEUE_DEPTH];
  logic [vt4_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [vt4_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [vt4_pkg::QCNT_W-1:0]      count_q, count_d;
  vt4_pkg::cmd_t                   cmd;
  logic                            push;
  logic                            pop;

  // Classify the incoming item into a command.
  always_comb begin
    cmd = '0;
    cmd.index = in_i.entry_index;
    if (in_i.func) begin
      cmd.op      = vt4_pkg::OP_XFORM;
      cmd.opnd[0] = in_i.vec_x;
      cmd.opnd[1] = in_i.vec_y;
      cmd.opnd[2] = in_i.vec_z;
      cmd.opnd[3] = in_i.vec_w;
    end else begin
      cmd.op      = vt4_pkg::OP_WRITE;
      cmd.opnd[0] = in_i.entry_value;
    end
  end

  assign in_i.ready   = (count_q != vt4_pkg::QCNT_W'(vt4_pkg::QUEUE_DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = queue_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == vt4_pkg::QPTR_W'(vt4_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == vt4_pkg::QPTR_W'(vt4_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/vt4_back.sv
// Back end: matrix store, product stage, adder stage and saturating output register.
`default_nettype none

module vt4_back #(
  parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vt4_pkg::cmd_t head_i,
  input  wire logic          head_valid_i,
  output logic               pop_o,
  vt4_out_if.source          out_o
);

  localparam int unsigned W      = vt4_pkg::WORD_W;
  localparam int unsigned PROD_W = 2 * W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DIM    = vt4_pkg::MAT_DIM;

  logic [vt4_pkg::MAT_ENTRIES-1:0][W-1:0] mat_q;

  logic signed [PROD_W-1:0] prod_q [DIM][DIM];
  logic signed [PAIR_W-1:0] pair_q [DIM][2];
  logic signed [W-1:0]      res_q  [DIM];
  logic signed [W-1:0]      res_d  [DIM];
  logic                     ovf_q, ovf_d;

  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_ready, s1_ready;
  logic do_write, do_xform;

  // Stage handshakes: a stage takes new data when it is empty or drains.
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_ready = !s2_valid_q || out_free;
  assign s1_ready = !s1_valid_q || s2_ready;

  // A matrix write always retires; a transform needs room in the product stage.
  assign do_write = head_valid_i && (head_i.op == vt4_pkg::OP_WRITE);
  assign do_xform = head_valid_i && (head_i.op == vt4_pkg::OP_XFORM) && s1_ready;
  assign pop_o    = do_write || do_xform;

  // Matrix store, cleared to zero at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
    end else if (do_write) begin
      mat_q[head_i.index] <= head_i.opnd[0];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= do_xform;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Product stage: sixteen full-width products, read against the current matrix.
  always_ff @(posedge clk_i) begin
    if (do_xform) begin
      for (int r = 0; r < DIM; r++) begin
        for (int k = 0; k < DIM; k++) begin
          prod_q[r][k] <= $signed(mat_q[r*DIM + k]) * $signed(head_i.opnd[k]);
        end
      end
    end
  end

  // Adder stage: pairwise sums of each row.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      for (int r = 0; r < DIM; r++) begin
        for (int j = 0; j < 2; j++) begin
          pair_q[r][j] <= PAIR_W'(prod_q[r][2*j]) + PAIR_W'(prod_q[r][2*j+1]);
        end
      end
    end
  end

  // Final sum, floor shift and saturation to 32 bits.
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    logic [SUM_W-W:0]        upper;
    ovf_d = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      sum     = SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      shifted = sum >>> FRAC_BITS;
      upper   = shifted[SUM_W-1:W-1];
      if ((&upper) || !(|upper)) begin
        res_d[r] = shifted[W-1:0];
      end else begin
        ovf_d    = 1'b1;
        res_d[r] = shifted[SUM_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_free) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_x    = res_q[0];
  assign out_o.out_y    = res_q[1];
  assign out_o.out_z    = res_q[2];
  assign out_o.out_w    = res_q[3];
  assign out_o.overflow = ovf_q;

endmodule

`default_nettype wire

// File: src/vt4_checker.sv
// Port-level checks for the vertex transform unit, bound to the top level.
`default_nettype none

module vt4_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_x,
  input wire logic [31:0] out_y,
  input wire logic [31:0] out_z,
  input wire logic [31:0] out_w,
  input wire logic        out_overflow
);

  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  logic [7:0] pending_q;
  logic       xform_in;
  logic       result_out;

  assign xform_in   = in_valid && in_ready && in_func;
  assign result_out = out_valid && out_ready;

  // Count transforms accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(xform_in) - 8'(result_out);
    end
  end

  // A stalled result stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
                                && $stable(out_w) && $stable(out_overflow))
    else $error("result payload changed while stalled");

  // Every result belongs to an earlier vertex transaction.
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != 8'd0)
    else $error("result without a pending vertex");

  // The overflow flag implies at least one saturated component.
  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_overflow |->
      out_x == INT_MAX || out_x == INT_MIN || out_y == INT_MAX || out_y == INT_MIN ||
      out_z == INT_MAX || out_z == INT_MIN || out_w == INT_MAX || out_w == INT_MIN)
    else $error("overflow set with no saturated component");

endmodule

bind vertex_transform_4x4_unit vt4_checker u_vt4_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_func      (in_i.func),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_x        (out_o.out_x),
  .out_y        (out_o.out_y),
  .out_z        (out_o.out_z),
  .out_w        (out_o.out_w),
  .out_overflow (out_o.overflow)
);

`default_nettype wire
